>>> sv/tpps_pkg.sv
// ----------------------------------------------------------------------------
// Timer prescaler/period solver package
// Shared widths, constants and the divider code table.
// ----------------------------------------------------------------------------
package tpps_pkg;

  localparam int unsigned FIELD_W      = 28;
  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned SHIFT_W      = 4;
  localparam int unsigned CODE_W       = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned DIV_CNT_W    = $clog2(FIELD_W);

  localparam logic [SHIFT_W-1:0]  MAX_SHIFT   = SHIFT_W'(10);
  localparam logic [FIELD_W-1:0]  CLOCK_RESET = FIELD_W'(48000000);
  localparam logic [FIELD_W-1:0]  TOP_LIMIT   = FIELD_W'((64'd1 << COUNTER_BITS) - 64'd1);
  // quotient above this still needs more prescale
  localparam logic [FIELD_W-1:0]  Q_LIMIT     = FIELD_W'(64'd1 << COUNTER_BITS);

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLAMPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  // exponents with no divider
  function automatic logic shift_skipped(input logic [SHIFT_W-1:0] shift);
    return (shift == SHIFT_W'(5)) || (shift == SHIFT_W'(7)) || (shift == SHIFT_W'(9));
  endfunction

  function automatic logic [CODE_W-1:0] divider_code(input logic [SHIFT_W-1:0] shift);
    logic [CODE_W-1:0] code;
    unique case (shift)
      SHIFT_W'(0):  code = CODE_W'(0);
      SHIFT_W'(1):  code = CODE_W'(1);
      SHIFT_W'(2):  code = CODE_W'(2);
      SHIFT_W'(3):  code = CODE_W'(3);
      SHIFT_W'(4):  code = CODE_W'(4);
      SHIFT_W'(6):  code = CODE_W'(5);
      SHIFT_W'(8):  code = CODE_W'(6);
      SHIFT_W'(10): code = CODE_W'(7);
      default:      code = CODE_W'(0);
    endcase
    return code;
  endfunction

endpackage

>>> sv/tpps_divider.sv
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; a go_i while running restarts it.
// ----------------------------------------------------------------------------
module tpps_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [tpps_pkg::FIELD_W-1:0] dividend_i,
  input  logic [tpps_pkg::FIELD_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [tpps_pkg::FIELD_W-1:0] quotient_o
);
  import tpps_pkg::*;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FIELD_W-1:0]   rem_q, rem_d;
  logic [FIELD_W-1:0]   quo_q, quo_d;
  logic [FIELD_W-1:0]   dvs_q, dvs_d;
  logic [FIELD_W:0]     trial;
  logic [FIELD_W:0]     diff;

  assign trial = {rem_q, quo_q[FIELD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (diff[FIELD_W]) begin
        rem_d = trial[FIELD_W-1:0];
      end else begin
        rem_d = diff[FIELD_W-1:0];
      end
      quo_d = {quo_q[FIELD_W-2:0], ~diff[FIELD_W]};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(FIELD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/timer_prescaler_period_solver.sv
// ----------------------------------------------------------------------------
// Timer prescaler and period solver
// Picks a prescale divider and counter top for a wanted interrupt rate.
// An invalid rate is answered in the cycle after start; else the steps are
// divide, hand-off, search, finish. Throughput: an invalid rate every cycle;
// a valid one keeps busy until done; result_valid_o pulses once, cannot stall.
// Reset: asynchronous, sets clock_hz to 48000000 and returns to idle.
// ----------------------------------------------------------------------------
module timer_prescaler_period_solver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clock_hz_we_i,
  input  logic [tpps_pkg::FIELD_W-1:0]  clock_hz_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [tpps_pkg::FIELD_W-1:0]  rate_hz_i,
  output logic                          result_valid_o,
  output logic [tpps_pkg::CODE_W-1:0]   prescale_code_o,
  output logic [tpps_pkg::SHIFT_W-1:0]  prescale_shift_o,
  output logic [tpps_pkg::COUNTER_BITS-1:0] period_top_o,
  output logic [tpps_pkg::STATUS_W-1:0] status_o
);
  import tpps_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [FIELD_W-1:0]      clock_q, clock_d;
  logic [FIELD_W-1:0]      d_q, d_d;
  logic [SHIFT_W-1:0]      shift_q, shift_d;
  logic                    valid_q, valid_d;
  logic [CODE_W-1:0]       code_q, code_d;
  logic [SHIFT_W-1:0]      oshift_q, oshift_d;
  logic [COUNTER_BITS-1:0] top_q, top_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic                    accept;
  logic                    invalid;
  logic                    div_done;
  logic [FIELD_W-1:0]      quotient;
  logic [FIELD_W-1:0]      d_minus;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign invalid = (rate_hz_i == '0) || (rate_hz_i > clock_q);
  assign d_minus = d_q - FIELD_W'(1);

  tpps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (accept && !invalid),
    .dividend_i (clock_q),
    .divisor_i  (rate_hz_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d  = state_q;
    clock_d  = clock_q;
    d_d      = d_q;
    shift_d  = shift_q;
    valid_d  = 1'b0;
    code_d   = code_q;
    oshift_d = oshift_q;
    top_d    = top_q;
    status_d = status_q;
    if (clock_hz_we_i) begin
      clock_d = clock_hz_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (invalid) begin
            valid_d  = 1'b1;
            code_d   = '0;
            oshift_d = '0;
            top_d    = '0;
            status_d = STATUS_INVALID;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          d_d     = quotient;
          shift_d = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if ((shift_q < MAX_SHIFT) && (d_q > Q_LIMIT)) begin
          shift_d = shift_q + SHIFT_W'(1);
          d_d     = d_q >> 1;
        end else begin
          if (shift_skipped(shift_q) && (shift_q < MAX_SHIFT)) begin
            shift_d = shift_q + SHIFT_W'(1);
            d_d     = d_q >> 1;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        valid_d  = 1'b1;
        code_d   = divider_code(shift_q);
        oshift_d = shift_q;
        if (d_q == '0) begin
          top_d    = '0;
          status_d = STATUS_OK;
        end else if (d_minus > TOP_LIMIT) begin
          top_d    = TOP_LIMIT[COUNTER_BITS-1:0];
          status_d = STATUS_CLAMPED;
        end else begin
          top_d    = d_minus[COUNTER_BITS-1:0];
          status_d = STATUS_OK;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clock_q <= CLOCK_RESET;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clock_q <= clock_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q      <= d_d;
    shift_q  <= shift_d;
    code_q   <= code_d;
    oshift_q <= oshift_d;
    top_q    <= top_d;
    status_q <= status_d;
  end

  assign result_valid_o   = valid_q;
  assign prescale_code_o  = code_q;
  assign prescale_shift_o = oshift_q;
  assign period_top_o     = top_q;
  assign status_o         = status_q;

endmodule
